// ----- rtl/lruc_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// Used by lruc_cell and lru_key_value_cache_unit; depends on nothing.
package lruc_pkg;

  localparam int ENTRIES = 16;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int PADDR_W = 3;

  localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE     = {DATA_W{1'b1}};

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } entry_t;

endpackage

// ----- rtl/lruc_cell.sv -----
// One slot of the recency-ordered chain: holds an entry and matches its key.
// Depends on lruc_pkg.
module lruc_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  lruc_pkg::entry_t             din,
  input  logic [lruc_pkg::DATA_W-1:0]  lookup_key,
  output lruc_pkg::entry_t             dout,
  output logic                         match
);

  logic                        valid;
  logic [lruc_pkg::DATA_W-1:0] key;
  logic [lruc_pkg::DATA_W-1:0] value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key   <= din.key;
      value <= din.value;
    end
  end

  assign match = valid && (key == lookup_key);

  always_comb begin
    dout.valid = valid;
    dout.key   = key;
    dout.value = value;
  end

endmodule

// ----- rtl/lru_key_value_cache_unit.sv -----
// Top level of the LRU key-value cache: a chain of lruc_cell slots kept in
// recency order, the lookup control and the APB configuration register.
// Depends on lruc_pkg and lruc_cell.
//
//   channel   handshake            payload
//   command   start (busy low)     kind, lookup_key, store_value
//   result    done strobe          hit, read_value
//   config    APB write/read       capacity at byte address 0
//
// One transaction per cycle: the key compare across all slots and the one-step
// shift of the chain happen at the accepting edge; the result strobes in the
// following cycle. busy stays low. Slot 0 holds the most recent entry.
// Reset clears every valid mark and the occupancy and sets capacity to 16.
// The receiver cannot stall; each result is shown for exactly one cycle.
module lru_key_value_cache_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic signed [lruc_pkg::DATA_W-1:0] lookup_key,
  input  logic signed [lruc_pkg::DATA_W-1:0] store_value,
  output logic                          done,
  output logic                          hit,
  output logic signed [lruc_pkg::DATA_W-1:0] read_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lruc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int N = lruc_pkg::ENTRIES;

  logic [lruc_pkg::CAP_W-1:0] capacity;
  logic [lruc_pkg::OCC_W-1:0] occupancy;
  logic [lruc_pkg::OCC_W-1:0] occupancy_next;

  lruc_pkg::entry_t          cell_q [N];
  lruc_pkg::entry_t          head;
  logic [N-1:0]              match;
  logic [N-1:0]              valid_vec;
  logic [N-1:0]              free_pos;
  logic [N-1:0]              last_pos;
  logic [N-1:0]              sel;
  logic [N-1:0]              load;
  logic [lruc_pkg::DATA_W-1:0] hit_value;
  logic [lruc_pkg::CMP_W-1:0]  cap_eff;
  lruc_pkg::op_t             op;
  logic                      accept;
  logic                      any_hit;
  logic                      occ_full;
  logic                      update;
  logic                      cfg_write;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign op     = lruc_pkg::op_t'(kind);

  // configuration register
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lruc_pkg::CAPACITY_RESET;
    end else if (cfg_write && (lruc_pkg::reg_idx_t'(paddr[2]) == lruc_pkg::REG_CAPACITY)) begin
      capacity <= pwdata[lruc_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (lruc_pkg::reg_idx_t'(paddr[2]) == lruc_pkg::REG_CAPACITY) begin
      prdata = 32'(capacity);
    end
  end

  always_comb begin
    if (capacity == '0) begin
      cap_eff = lruc_pkg::CMP_W'(1);
    end else if (lruc_pkg::CMP_W'(capacity) > lruc_pkg::CMP_W'(N)) begin
      cap_eff = lruc_pkg::CMP_W'(N);
    end else begin
      cap_eff = lruc_pkg::CMP_W'(capacity);
    end
  end

  assign occ_full = lruc_pkg::CMP_W'(occupancy) >= cap_eff;

  // slot chain
  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      localparam logic [N-1:0] SUFFIX = {N{1'b1}} << i;

      lruc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .load       (load[i]),
        .din        ((i == 0) ? head : cell_q[(i == 0) ? 0 : i - 1]),
        .lookup_key (lookup_key),
        .dout       (cell_q[i]),
        .match      (match[i])
      );

      assign valid_vec[i] = cell_q[i].valid;
      assign load[i]      = update && ((i == 0) || ((sel & SUFFIX) != '0));

      if (i == 0) begin : g_first
        assign free_pos[i] = !valid_vec[i];
      end else begin : g_rest
        assign free_pos[i] = !valid_vec[i] && valid_vec[i-1];
      end

      if (i == N - 1) begin : g_tail
        assign last_pos[i] = valid_vec[i];
      end else begin : g_body
        assign last_pos[i] = valid_vec[i] && !valid_vec[i+1];
      end
    end
  endgenerate

  always_comb begin
    hit_value = '0;
    for (int j = 0; j < N; j++) begin
      hit_value = hit_value | (cell_q[j].value & {lruc_pkg::DATA_W{match[j]}});
    end
  end

  assign any_hit = |match;
  assign update  = accept && (any_hit || (op == lruc_pkg::OP_PUT));

  always_comb begin
    if (any_hit) begin
      sel = match;
    end else if (occ_full) begin
      sel = last_pos;
    end else begin
      sel = free_pos;
    end
  end

  always_comb begin
    head.valid = 1'b1;
    head.key   = lookup_key;
    head.value = (op == lruc_pkg::OP_PUT) ? store_value : hit_value;
  end

  always_comb begin
    occupancy_next = occupancy;
    if (accept && (op == lruc_pkg::OP_PUT) && !any_hit && !occ_full) begin
      occupancy_next = occupancy + lruc_pkg::OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      done      <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      done      <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit <= any_hit;
      if (op == lruc_pkg::OP_PUT) begin
        read_value <= '0;
      end else if (any_hit) begin
        read_value <= hit_value;
      end else begin
        read_value <= lruc_pkg::MISS_VALUE;
      end
    end
  end

endmodule

// ----- tb/lru_key_value_cache_unit_tb.sv -----
// Self-checking testbench for lru_key_value_cache_unit: directed and random get/put
// traffic against a behavioral LRU store, with APB capacity writes between phases.
// Depends on lruc_pkg and the cache RTL.
module lru_key_value_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMEOUT_CYCLES = 100000;
  localparam logic [lruc_pkg::PADDR_W-1:0] CAPACITY_ADDR =
    lruc_pkg::PADDR_W'({lruc_pkg::REG_CAPACITY, 2'b00});
  localparam logic [lruc_pkg::PADDR_W-1:0] UNMAPPED_ADDR = lruc_pkg::PADDR_W'(4);

  typedef struct packed {
    logic                        hit;
    logic [lruc_pkg::DATA_W-1:0] value;
  } lookup_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          kind = 1'b0;
  logic [lruc_pkg::DATA_W-1:0]   lookup_key = '0;
  logic [lruc_pkg::DATA_W-1:0]   store_value = '0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [lruc_pkg::PADDR_W-1:0]  paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic                          busy;
  logic                          done;
  logic                          hit;
  logic [lruc_pkg::DATA_W-1:0]   read_value;
  logic [31:0]                   prdata;
  logic                          pready;

  logic [lruc_pkg::DATA_W-1:0]   model_key [lruc_pkg::ENTRIES];
  logic [lruc_pkg::DATA_W-1:0]   model_value [lruc_pkg::ENTRIES];
  bit                            model_valid [lruc_pkg::ENTRIES];
  int unsigned                   model_rank [lruc_pkg::ENTRIES];
  int unsigned                   model_occupancy = 0;
  logic [lruc_pkg::CAP_W-1:0]    model_capacity = lruc_pkg::CAPACITY_RESET;

  lookup_result_t                pending_lookups[$];
  logic [lruc_pkg::DATA_W-1:0]   key_pool [32];
  int                            error_count = 0;
  int                            cycle_count = 0;

  lru_key_value_cache_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .lookup_key(lookup_key),
    .store_value(store_value),
    .done(done),
    .hit(hit),
    .read_value(read_value),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < lruc_pkg::ENTRIES; i++) begin
      model_key[i] = '0;
      model_value[i] = '0;
      model_valid[i] = 1'b0;
      model_rank[i] = 0;
    end
  end

  function automatic void make_most_recent(int slot);
    int unsigned r;
    r = model_rank[slot];
    for (int i = 0; i < lruc_pkg::ENTRIES; i++)
      if (model_valid[i] && i != slot && model_rank[i] < r)
        model_rank[i]++;
    model_rank[slot] = 0;
  endfunction

  function automatic lookup_result_t cache_access(lruc_pkg::op_t op,
                                                  logic [lruc_pkg::DATA_W-1:0] key,
                                                  logic [lruc_pkg::DATA_W-1:0] value);
    int unsigned eff_capacity;
    int slot;
    bit found;
    lookup_result_t res;
    eff_capacity = model_capacity;
    if (eff_capacity < 1)
      eff_capacity = 1;
    if (eff_capacity > lruc_pkg::ENTRIES)
      eff_capacity = lruc_pkg::ENTRIES;
    slot = -1;
    for (int i = 0; i < lruc_pkg::ENTRIES; i++)
      if (slot < 0 && model_valid[i] && model_key[i] == key)
        slot = i;
    if (op == lruc_pkg::OP_GET) begin
      if (slot >= 0) begin
        make_most_recent(slot);
        res = '{1'b1, model_value[slot]};
      end else begin
        res = '{1'b0, lruc_pkg::MISS_VALUE};
      end
      return res;
    end
    if (slot >= 0) begin
      model_value[slot] = value;
      make_most_recent(slot);
      return '{1'b1, '0};
    end
    if (model_occupancy >= eff_capacity) begin
      found = 1'b0;
      slot = 0;
      for (int i = 0; i < lruc_pkg::ENTRIES; i++)
        if (model_valid[i] && (!found || model_rank[i] > model_rank[slot])) begin
          slot = i;
          found = 1'b1;
        end
      make_most_recent(slot);
    end else begin
      slot = -1;
      for (int i = 0; i < lruc_pkg::ENTRIES; i++)
        if (slot < 0 && !model_valid[i])
          slot = i;
      for (int i = 0; i < lruc_pkg::ENTRIES; i++)
        if (model_valid[i])
          model_rank[i]++;
      model_rank[slot] = 0;
      model_valid[slot] = 1'b1;
      model_occupancy++;
    end
    model_key[slot] = key;
    model_value[slot] = value;
    return '{1'b0, '0};
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && done) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit=%0b value=%0h",
                 $time, hit, read_value);
        error_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, hit);
          error_count++;
        end
        if (read_value !== want.value) begin
          $display("%0t: read_value mismatch, expected %0h, actual %0h",
                   $time, want.value, read_value);
          error_count++;
        end
      end
    end
  end

  task automatic send_op(lruc_pkg::op_t op, logic [lruc_pkg::DATA_W-1:0] key,
                         logic [lruc_pkg::DATA_W-1:0] value);
    start <= 1'b1;
    kind <= op;
    lookup_key <= key;
    store_value <= value;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    pending_lookups.push_back(cache_access(op, key, value));
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_lookups.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_access(logic write, logic [lruc_pkg::PADDR_W-1:0] addr,
                            logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    rdata = prdata;
    if (write && addr == CAPACITY_ADDR)
      model_capacity = wdata[lruc_pkg::CAP_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_capacity_reg();
    logic [31:0] rdata;
    apb_access(1'b0, CAPACITY_ADDR, $urandom(), rdata);
    if (rdata !== 32'(model_capacity)) begin
      $display("%0t: capacity readback mismatch, expected %0h, actual %0h",
               $time, 32'(model_capacity), rdata);
      error_count++;
    end
  endtask

  task automatic set_capacity(logic [lruc_pkg::CAP_W-1:0] cap);
    logic [31:0] rdata;
    wait_drained();
    apb_access(1'b1, CAPACITY_ADDR, {(32 - lruc_pkg::CAP_W)'($urandom()), cap}, rdata);
    check_capacity_reg();
  endtask

  task automatic test_reset_state();
    check_capacity_reg();
    send_op(lruc_pkg::OP_GET, '0, $urandom());
  endtask

  task automatic test_extreme_keys();
    send_op(lruc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(lruc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(lruc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(lruc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(lruc_pkg::OP_GET, 32'h8000_0000, '0);
    send_op(lruc_pkg::OP_GET, 32'h7FFF_FFFF, '1);
    send_op(lruc_pkg::OP_GET, 32'h0000_0000, '0);
    send_op(lruc_pkg::OP_GET, 32'hFFFF_FFFF, '1);
    send_op(lruc_pkg::OP_PUT, 32'h8000_0000, 32'h1234_5678);
    send_op(lruc_pkg::OP_GET, 32'h8000_0000, '0);
    send_op(lruc_pkg::OP_GET, 32'h0000_0001, '0);
  endtask

  task automatic test_capacity_floor();
    set_capacity(5'd0);
    send_op(lruc_pkg::OP_PUT, 32'd1, 32'd10);
    send_op(lruc_pkg::OP_PUT, 32'd2, 32'd20);
    send_op(lruc_pkg::OP_GET, 32'd1, '0);
    send_op(lruc_pkg::OP_GET, 32'd2, '0);
  endtask

  task automatic test_capacity_shrink();
    set_capacity(5'd6);
    send_op(lruc_pkg::OP_PUT, 32'd101, 32'd1001);
    send_op(lruc_pkg::OP_PUT, 32'd102, 32'd1002);
    set_capacity(5'd2);
    send_op(lruc_pkg::OP_PUT, 32'd103, 32'd1003);
    send_op(lruc_pkg::OP_GET, 32'hFFFF_FFFF, '0);
    send_op(lruc_pkg::OP_GET, 32'd101, '0);
    send_op(lruc_pkg::OP_GET, 32'd103, '0);
  endtask

  task automatic test_unmapped_write();
    logic [31:0] rdata;
    wait_drained();
    apb_access(1'b1, UNMAPPED_ADDR, $urandom(), rdata);
    check_capacity_reg();
  endtask

  task automatic run_random_traffic(int count, int pool_size, int max_gap);
    int burst_left;
    lruc_pkg::op_t op;
    logic [lruc_pkg::DATA_W-1:0] key;
    burst_left = 0;
    for (int i = 0; i < pool_size; i++)
      key_pool[i] = $urandom();
    for (int n = 0; n < count; n++) begin
      if (n == count / 2)
        wait_drained();
      if (burst_left == 0) begin
        if (max_gap > 0)
          pause_sender($urandom_range(1, max_gap));
        burst_left = $urandom_range(1, 24);
      end
      op = lruc_pkg::op_t'($urandom_range(0, 1));
      key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, pool_size - 1)];
      send_op(op, key, $urandom());
      burst_left--;
    end
  endtask

  task automatic test_random_traffic();
    logic [lruc_pkg::CAP_W-1:0] mid_cap;
    set_capacity(5'd16);
    run_random_traffic(300, 20, 6);
    set_capacity(5'd1);
    run_random_traffic(120, 4, 6);
    set_capacity(5'd31);
    run_random_traffic(200, 24, 0);
    set_capacity(5'd17);
    run_random_traffic(150, 20, 3);
    mid_cap = lruc_pkg::CAP_W'($urandom_range(2, 15));
    set_capacity(mid_cap);
    run_random_traffic(250, int'(mid_cap) + 4, 8);
    set_capacity(5'd12);
    run_random_traffic(120, 16, 4);
    set_capacity(5'd3);
    run_random_traffic(140, 8, 4);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_extreme_keys();
    test_capacity_floor();
    test_capacity_shrink();
    test_unmapped_write();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
